// ===== hdl/ajrb_pkg.sv =====
`timescale 1ns / 1ps

package ajrb_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PF_W   = 4;
    localparam int CMP_W  = (CNT_W > PF_W) ? CNT_W : PF_W;
    localparam int SEQ_W  = 16;
    localparam int HDL_W  = 16;
    localparam int SIZE_W = 8;
    localparam int RUN_W  = 16;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [PF_W-1:0] PREFILL_RESET = 4'd3;

    typedef enum logic [1:0] {
        REQ_AUDIO   = 2'd0,
        REQ_HAPTIC  = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        RES_PLAY    = 2'd0,
        RES_CONCEAL = 2'd1,
        RES_HAPTIC  = 2'd2,
        RES_DISCARD = 2'd3
    } t_res_kind;

    typedef struct packed {
        t_req_kind         kind;
        logic [SEQ_W-1:0]  seq;
        logic [HDL_W-1:0]  handle;
        logic [SIZE_W-1:0] size;
    } t_req;

    typedef struct packed {
        t_res_kind         kind;
        logic [SEQ_W-1:0]  seq;
        logic [HDL_W-1:0]  handle;
        logic [SIZE_W-1:0] size;
        logic [RUN_W-1:0]  run;
    } t_result;

    typedef struct packed {
        logic    valid;
        logic    flush;
        t_result res;
    } t_emit;

    // a is newer than b when (a - b) mod 2^16 lies in 1..32767.
    function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

// ===== hdl/audio_jitter_reorder_buffer.sv =====
`timescale 1ns / 1ps
// Flow: requests wait in a two-entry queue, and the engine takes the next one only while idle;
// it handles one request at a time, scanning the slots where needed, and ends each with a flush.
// Receiver stalls hold the engine once the result registers are full.
// Reset: synchronous, active low; slots empty, sequencing cleared, prefill count 3.
module audio_jitter_reorder_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [ajrb_pkg::SEQ_W-1:0]    i_seq_number,
    input  logic [ajrb_pkg::HDL_W-1:0]    i_payload_handle,
    input  logic [ajrb_pkg::SIZE_W-1:0]   i_payload_size,
    input  logic                          i_cfg_we,
    input  logic [ajrb_pkg::PF_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_result_kind,
    output logic [ajrb_pkg::SEQ_W-1:0]    o_out_seq,
    output logic [ajrb_pkg::HDL_W-1:0]    o_out_handle,
    output logic [ajrb_pkg::SIZE_W-1:0]   o_out_size,
    output logic [ajrb_pkg::RUN_W-1:0]    o_conceal_run,
    output logic                          o_last_of_run
);

    logic              q_valid;
    ajrb_pkg::t_req    q_req;
    logic              q_pop;
    ajrb_pkg::t_emit   emit;
    logic              room;
    ajrb_pkg::t_result res;

    ajrb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_seq_number     (i_seq_number),
        .i_payload_handle (i_payload_handle),
        .i_payload_size   (i_payload_size),
        .o_q_valid        (q_valid),
        .o_q_req          (q_req),
        .i_q_pop          (q_pop)
    );

    ajrb_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_req    (q_req),
        .o_q_pop    (q_pop),
        .o_emit     (emit),
        .i_room     (room)
    );

    ajrb_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res),
        .o_last  (o_last_of_run)
    );

    assign o_result_kind = res.kind;
    assign o_out_seq     = res.seq;
    assign o_out_handle  = res.handle;
    assign o_out_size    = res.size;
    assign o_conceal_run = res.run;

endmodule

// ===== hdl/ajrb_front.sv =====
`timescale 1ns / 1ps

module ajrb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [ajrb_pkg::SEQ_W-1:0]  i_seq_number,
    input  logic [ajrb_pkg::HDL_W-1:0]  i_payload_handle,
    input  logic [ajrb_pkg::SIZE_W-1:0] i_payload_size,
    output logic                        o_q_valid,
    output ajrb_pkg::t_req              o_q_req,
    input  logic                        i_q_pop
);

    ajrb_pkg::t_req                r_q [ajrb_pkg::QDEPTH];
    logic [ajrb_pkg::QPTR_W-1:0]  r_wr;
    logic [ajrb_pkg::QPTR_W-1:0]  r_rd;
    logic [ajrb_pkg::QCNT_W-1:0]  r_cnt;
    logic                          known;
    logic                          push;
    logic                          pop;
    ajrb_pkg::t_req                req;

    assign o_ready   = (r_cnt != ajrb_pkg::QCNT_W'(ajrb_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_q[r_rd];

    always_comb begin
        req.kind   = ajrb_pkg::t_req_kind'(i_req_type);
        req.seq    = i_seq_number;
        req.handle = i_payload_handle;
        req.size   = i_payload_size;
        case (req.kind)
            ajrb_pkg::REQ_AUDIO, ajrb_pkg::REQ_HAPTIC, ajrb_pkg::REQ_RESTART: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    // The unused request type is accepted and dropped here: it has no results.
    assign push = i_valid && o_ready && known;
    assign pop  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= req;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == ajrb_pkg::QPTR_W'(ajrb_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == ajrb_pkg::QPTR_W'(ajrb_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ajrb_out.sv =====
`timescale 1ns / 1ps

module ajrb_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ajrb_pkg::t_emit     i_emit,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output ajrb_pkg::t_result   o_res,
    output logic                o_last
);

    // One result is held back until the next one (or the end of the request)
    // shows whether it is the last of its request.
    logic              r_pend_v;
    ajrb_pkg::t_result r_pend;
    logic              r_o_v;
    ajrb_pkg::t_result r_o;
    logic              r_o_last;
    logic              out_free;
    logic              load;

    assign out_free = !r_o_v || i_ready;
    assign o_room   = !r_pend_v || out_free;
    assign o_valid  = r_o_v;
    assign o_res    = r_o;
    assign o_last   = r_o_last;

    // The held result moves out when a newer one arrives or the request ends.
    assign load = o_room && r_pend_v && (i_emit.valid || i_emit.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            if (load) begin
                r_o      <= r_pend;
                r_o_last <= !i_emit.valid;
                r_o_v    <= 1'b1;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
            if (i_emit.valid && o_room) begin
                r_pend   <= i_emit.res;
                r_pend_v <= 1'b1;
            end else if (load) begin
                r_pend_v <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/ajrb_engine.sv =====
`timescale 1ns / 1ps

module ajrb_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ajrb_pkg::PF_W-1:0]     i_cfg_data,
    input  logic                          i_q_valid,
    input  ajrb_pkg::t_req                i_q_req,
    output logic                          o_q_pop,
    output ajrb_pkg::t_emit               o_emit,
    input  logic                          i_room
);

    typedef enum logic [3:0] {
        S_IDLE, S_HAP, S_AUD, S_SCAN, S_EVICT, S_DRAIN, S_CONC, S_CEMIT, S_RST, S_FLUSH
    } t_state;

    t_state                              r_state;
    t_state                              r_after;
    ajrb_pkg::t_req                      r_req;
    logic [ajrb_pkg::SLOTS-1:0]          r_sv;
    logic [ajrb_pkg::SEQ_W-1:0]          r_ss [ajrb_pkg::SLOTS];
    logic [ajrb_pkg::HDL_W-1:0]          r_sh [ajrb_pkg::SLOTS];
    logic [ajrb_pkg::SIZE_W-1:0]         r_sz [ajrb_pkg::SLOTS];
    logic [ajrb_pkg::CNT_W-1:0]          r_held;
    logic [ajrb_pkg::SEQ_W-1:0]          r_nd;
    logic                                r_ndv;
    logic                                r_playing;
    logic [ajrb_pkg::SEQ_W-1:0]          r_lp;
    logic [ajrb_pkg::PF_W-1:0]           r_pf;
    logic [ajrb_pkg::SLOT_W-1:0]         r_idx;
    logic                                r_have;
    logic                                r_fresh;
    logic [ajrb_pkg::SLOT_W-1:0]         r_new;
    logic [ajrb_pkg::SEQ_W-1:0]          r_old_seq;
    logic [ajrb_pkg::SEQ_W-1:0]          r_new_seq;
    logic [ajrb_pkg::SEQ_W-1:0]          r_first;
    logic [ajrb_pkg::RUN_W-1:0]          r_run;

    logic [ajrb_pkg::SEQ_W-1:0]          key;
    logic                                hit_any;
    logic [ajrb_pkg::SLOT_W-1:0]         hit_idx;
    logic                                free_any;
    logic [ajrb_pkg::SLOT_W-1:0]         free_idx;
    logic [ajrb_pkg::SLOT_W-1:0]         rd_addr;
    logic [ajrb_pkg::SEQ_W-1:0]          rd_seq;
    logic [ajrb_pkg::HDL_W-1:0]          rd_hdl;
    logic [ajrb_pkg::SIZE_W-1:0]         rd_size;
    logic                                late;
    logic                                evict_ok;
    logic                                full_pf;
    logic [ajrb_pkg::SEQ_W-1:0]          nd_look;
    logic                                may;
    logic                                idx_last;
    ajrb_pkg::t_emit                     em;

    assign idx_last = (r_idx == ajrb_pkg::SLOT_W'(ajrb_pkg::SLOTS - 1));
    assign full_pf  = (ajrb_pkg::CMP_W'(r_held) >= ajrb_pkg::CMP_W'(r_pf));
    assign nd_look  = r_nd + {{(ajrb_pkg::SEQ_W - ajrb_pkg::PF_W){1'b0}}, r_pf}
                      - ajrb_pkg::SEQ_W'(1);
    assign late     = r_ndv && ajrb_pkg::seq_newer(r_nd, r_req.seq);
    assign evict_ok = r_have && ajrb_pkg::seq_newer(r_new_seq, r_req.seq);
    assign may      = (r_held != '0) && r_have && ajrb_pkg::seq_newer(r_old_seq, r_nd)
                      && (!full_pf || ajrb_pkg::seq_newer(r_new_seq, nd_look));

    // Parallel match and free-slot search; the lowest slot index wins.
    always_comb begin
        case (r_state)
            S_AUD:   key = r_req.seq;
            S_CONC:  key = r_nd + ajrb_pkg::SEQ_W'(1);
            default: key = r_nd;
        endcase
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ajrb_pkg::SLOTS - 1; i >= 0; i--) begin
            if (r_sv[i] && (r_ss[i] == key)) begin
                hit_any = 1'b1;
                hit_idx = ajrb_pkg::SLOT_W'(i);
            end
            if (!r_sv[i]) begin
                free_any = 1'b1;
                free_idx = ajrb_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        case (r_state)
            S_EVICT: rd_addr = r_new;
            S_DRAIN: rd_addr = hit_idx;
            default: rd_addr = r_idx;
        endcase
    end

    assign rd_seq  = r_ss[rd_addr];
    assign rd_hdl  = r_sh[rd_addr];
    assign rd_size = r_sz[rd_addr];

    always_comb begin
        em.valid      = 1'b0;
        em.flush      = (r_state == S_FLUSH);
        em.res.kind   = ajrb_pkg::RES_DISCARD;
        em.res.seq    = r_req.seq;
        em.res.handle = r_req.handle;
        em.res.size   = r_req.size;
        em.res.run    = '0;
        case (r_state)
            S_HAP: begin
                em.valid = 1'b1;
                if (ajrb_pkg::seq_newer(r_req.seq, r_lp)) begin
                    em.res.kind = ajrb_pkg::RES_HAPTIC;
                end
            end
            S_AUD: begin
                em.valid = late || hit_any;
            end
            S_EVICT: begin
                em.valid = 1'b1;
                if (evict_ok) begin
                    em.res.seq    = rd_seq;
                    em.res.handle = rd_hdl;
                    em.res.size   = rd_size;
                end
            end
            S_RST: begin
                em.valid      = r_sv[r_idx];
                em.res.seq    = rd_seq;
                em.res.handle = rd_hdl;
                em.res.size   = rd_size;
            end
            S_DRAIN: begin
                em.valid      = r_playing && hit_any;
                em.res.kind   = ajrb_pkg::RES_PLAY;
                em.res.seq    = rd_seq;
                em.res.handle = rd_hdl;
                em.res.size   = rd_size;
            end
            S_CEMIT: begin
                em.valid      = 1'b1;
                em.res.kind   = ajrb_pkg::RES_CONCEAL;
                em.res.seq    = r_first;
                em.res.handle = '0;
                em.res.size   = '0;
                em.res.run    = r_run;
            end
            default: em.valid = 1'b0;
        endcase
    end

    assign o_emit  = em;
    assign o_q_pop = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_DRAIN;
            r_sv      <= '0;
            r_held    <= '0;
            r_nd      <= '0;
            r_ndv     <= 1'b0;
            r_playing <= 1'b0;
            r_lp      <= '0;
            r_pf      <= ajrb_pkg::PREFILL_RESET;
            r_idx     <= '0;
            r_have    <= 1'b0;
            r_fresh   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pf <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req <= i_q_req;
                        r_idx <= '0;
                        case (i_q_req.kind)
                            ajrb_pkg::REQ_AUDIO:   r_state <= S_AUD;
                            ajrb_pkg::REQ_HAPTIC:  r_state <= S_HAP;
                            default:               r_state <= S_RST;
                        endcase
                    end
                end
                S_HAP: begin
                    if (i_room) begin
                        if (ajrb_pkg::seq_newer(r_req.seq, r_lp)) begin
                            r_lp <= r_req.seq;
                        end
                        r_state <= S_FLUSH;
                    end
                end
                S_AUD: begin
                    if (late || hit_any) begin
                        if (i_room) begin
                            r_state <= S_FLUSH;
                        end
                    end else if (free_any) begin
                        r_sv[free_idx] <= 1'b1;
                        r_ss[free_idx] <= r_req.seq;
                        r_sh[free_idx] <= r_req.handle;
                        r_sz[free_idx] <= r_req.size;
                        r_held         <= r_held + 1'b1;
                        r_fresh        <= 1'b0;
                        r_state        <= S_DRAIN;
                    end else begin
                        r_idx   <= '0;
                        r_have  <= 1'b0;
                        r_after <= S_EVICT;
                        r_state <= S_SCAN;
                    end
                end
                // Linear pass for the oldest and newest held numbers, in slot order,
                // since the wrapping order is not transitive.
                S_SCAN: begin
                    if (r_sv[r_idx]) begin
                        r_have <= 1'b1;
                        if (!r_have || ajrb_pkg::seq_newer(r_old_seq, rd_seq)) begin
                            r_old_seq <= rd_seq;
                        end
                        if (!r_have || ajrb_pkg::seq_newer(rd_seq, r_new_seq)) begin
                            r_new     <= r_idx;
                            r_new_seq <= rd_seq;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (idx_last) begin
                        r_fresh <= 1'b1;
                        r_state <= r_after;
                    end
                end
                S_EVICT: begin
                    if (i_room) begin
                        if (evict_ok) begin
                            r_ss[r_new] <= r_req.seq;
                            r_sh[r_new] <= r_req.handle;
                            r_sz[r_new] <= r_req.size;
                            r_fresh     <= 1'b0;
                            r_state     <= S_DRAIN;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_playing) begin
                        if (full_pf && !r_fresh) begin
                            r_idx   <= '0;
                            r_have  <= 1'b0;
                            r_after <= S_DRAIN;
                            r_state <= S_SCAN;
                        end else if (full_pf && r_have) begin
                            r_nd      <= r_old_seq;
                            r_ndv     <= 1'b1;
                            r_playing <= 1'b1;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end else if (hit_any) begin
                        if (i_room) begin
                            r_sv[hit_idx] <= 1'b0;
                            r_held        <= r_held - 1'b1;
                            r_lp          <= r_nd;
                            r_nd          <= r_nd + 1'b1;
                            r_fresh       <= 1'b0;
                        end
                    end else if (!r_fresh) begin
                        r_idx   <= '0;
                        r_have  <= 1'b0;
                        r_after <= S_DRAIN;
                        r_state <= S_SCAN;
                    end else begin
                        r_first <= r_nd;
                        r_run   <= '0;
                        r_state <= S_CONC;
                    end
                end
                // One concealed number per cycle; the run ends at the next held unit or when no more may be concealed.
                S_CONC: begin
                    if (may) begin
                        r_lp  <= r_nd;
                        r_nd  <= r_nd + 1'b1;
                        r_run <= r_run + 1'b1;
                        if (hit_any) begin
                            r_state <= S_CEMIT;
                        end
                    end else if (r_run == '0) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_CEMIT;
                    end
                end
                S_CEMIT: begin
                    if (i_room) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_RST: begin
                    if (!r_sv[r_idx] || i_room) begin
                        r_sv[r_idx] <= 1'b0;
                        if (r_sv[r_idx]) begin
                            r_held <= r_held - 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                        if (idx_last) begin
                            r_nd      <= '0;
                            r_ndv     <= 1'b0;
                            r_playing <= 1'b0;
                            r_lp      <= '0;
                            r_fresh   <= 1'b0;
                            r_state   <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (i_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_held_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ajrb_pkg::CNT_W'($countones(r_sv)) == r_held)
        else $error("held count does not match the valid slots");

    a_playing_has_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_ndv)
        else $error("playing without a due number");

    a_conceal_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONC && !may) |=> (r_state == S_FLUSH || r_state == S_CEMIT))
        else $error("concealment run did not end");
`endif

endmodule

// ===== test/ajrb_checker.sv =====
`timescale 1ns / 1ps

module ajrb_checker
    import ajrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready_in,
    input  logic [1:0]        i_req_type,
    input  logic [SEQ_W-1:0]  i_seq_number,
    input  logic [HDL_W-1:0]  i_payload_handle,
    input  logic [SIZE_W-1:0] i_payload_size,
    input  logic              i_cfg_we,
    input  logic [PF_W-1:0]   i_cfg_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_result_kind,
    input  logic [SEQ_W-1:0]  i_out_seq,
    input  logic [HDL_W-1:0]  i_out_handle,
    input  logic [SIZE_W-1:0] i_out_size,
    input  logic [RUN_W-1:0]  i_conceal_run,
    input  logic              i_last_of_run,
    output int                o_errors,
    output int                o_pending
);

    typedef struct {
        t_res_kind         kind;
        logic [SEQ_W-1:0]  seq;
        logic [HDL_W-1:0]  handle;
        logic [SIZE_W-1:0] size;
        logic [RUN_W-1:0]  run;
        logic              last;
    } t_exp;

    t_exp              expected_q[$];
    logic              held_v[SLOTS];
    logic [SEQ_W-1:0]  held_seq[SLOTS];
    logic [HDL_W-1:0]  held_hdl[SLOTS];
    logic [SIZE_W-1:0] held_size[SLOTS];
    int                held_cnt;
    logic [SEQ_W-1:0]  due_seq;
    logic              due_ok;
    logic              is_playing;
    logic [SEQ_W-1:0]  played_seq;
    int                prefill;
    int                step_n;

    assign o_pending = expected_q.size();

    function automatic logic newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d >= 1 && d <= 16'h7FFF;
    endfunction

    function automatic int slot_of(logic [SEQ_W-1:0] s);
        for (int i = 0; i < SLOTS; i++)
            if (held_v[i] && held_seq[i] == s) return i;
        return -1;
    endfunction

    function automatic int oldest_slot();
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++)
            if (held_v[i] && (b < 0 || newer(held_seq[b], held_seq[i]))) b = i;
        return b;
    endfunction

    function automatic int newest_slot();
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++)
            if (held_v[i] && (b < 0 || newer(held_seq[i], held_seq[b]))) b = i;
        return b;
    endfunction

    task automatic push(t_res_kind k, logic [SEQ_W-1:0] s, logic [HDL_W-1:0] h,
                        logic [SIZE_W-1:0] z, logic [RUN_W-1:0] r);
        t_exp e;
        e.kind = k; e.seq = s; e.handle = h; e.size = z; e.run = r; e.last = 1'b0;
        expected_q.push_back(e);
        step_n++;
    endtask

    function automatic logic gap_fillable();
        int o, w;
        logic [SEQ_W-1:0] horizon;
        o = oldest_slot();
        w = newest_slot();
        if (held_cnt == 0 || o < 0) return 1'b0;
        if (!newer(held_seq[o], due_seq)) return 1'b0;
        if (held_cnt >= prefill) begin
            horizon = due_seq + prefill[SEQ_W-1:0] - SEQ_W'(1);
            return newer(held_seq[w], horizon);
        end
        return 1'b1;
    endfunction

    task automatic play_out();
        int s, o;
        logic [SEQ_W-1:0] first;
        logic [RUN_W-1:0] run;
        forever begin
            if (!is_playing && held_cnt >= prefill) begin
                o = oldest_slot();
                if (o >= 0) begin
                    due_seq = held_seq[o]; due_ok = 1; is_playing = 1;
                end
            end
            if (!(is_playing && due_ok)) return;
            s = slot_of(due_seq);
            if (s >= 0) begin
                push(RES_PLAY, held_seq[s], held_hdl[s], held_size[s], '0);
                held_v[s] = 0; held_cnt--;
                played_seq = due_seq; due_seq++;
                continue;
            end
            first = due_seq;
            run = '0;
            while (gap_fillable()) begin
                played_seq = due_seq; due_seq++; run++;
                if (slot_of(due_seq) >= 0) break;
            end
            if (run == 0) return;
            push(RES_CONCEAL, first, '0, '0, run);
        end
    endtask

    task automatic clear_state();
        for (int i = 0; i < SLOTS; i++) held_v[i] = 0;
        held_cnt = 0; due_seq = 0; due_ok = 0; is_playing = 0; played_seq = 0;
    endtask

    task automatic predict(t_req_kind k, logic [SEQ_W-1:0] s, logic [HDL_W-1:0] h,
                           logic [SIZE_W-1:0] z);
        int slot, w;
        step_n = 0;
        case (k)
            REQ_RESTART: begin
                for (int i = 0; i < SLOTS; i++)
                    if (held_v[i]) push(RES_DISCARD, held_seq[i], held_hdl[i], held_size[i], '0);
                clear_state();
            end
            REQ_HAPTIC: begin
                if (newer(s, played_seq)) begin
                    played_seq = s;
                    push(RES_HAPTIC, s, h, z, '0);
                end else begin
                    push(RES_DISCARD, s, h, z, '0);
                end
            end
            REQ_AUDIO: begin
                if ((due_ok && newer(due_seq, s)) || slot_of(s) >= 0) begin
                    push(RES_DISCARD, s, h, z, '0);
                end else begin
                    slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) if (!held_v[i]) slot = i;
                    if (slot < 0) begin
                        w = newest_slot();
                        if (w >= 0 && newer(held_seq[w], s)) begin
                            push(RES_DISCARD, held_seq[w], held_hdl[w], held_size[w], '0);
                            held_v[w] = 0; held_cnt--;
                            slot = w;
                        end
                    end
                    if (slot < 0) begin
                        push(RES_DISCARD, s, h, z, '0);
                    end else begin
                        held_v[slot] = 1; held_seq[slot] = s;
                        held_hdl[slot] = h; held_size[slot] = z;
                        held_cnt++;
                        play_out();
                    end
                end
            end
            default: ;
        endcase
        if (step_n > 0) expected_q[$].last = 1'b1;
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        prefill = int'(PREFILL_RESET);
        clear_state();
    end

    always @(posedge i_clk) begin
        t_exp e;
        if (!i_rst_n) begin
            clear_state();
            prefill = int'(PREFILL_RESET);
        end else begin
            if (i_cfg_we) prefill = int'(i_cfg_data);
            if (i_valid && i_ready_in)
                predict(t_req_kind'(i_req_type), i_seq_number, i_payload_handle,
                        i_payload_size);
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", i_out_seq, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_result_kind != e.kind) report("kind", i_result_kind, e.kind);
                    if (i_out_seq != e.seq) report("seq", i_out_seq, e.seq);
                    if (i_out_handle != e.handle) report("handle", i_out_handle, e.handle);
                    if (i_out_size != e.size) report("size", i_out_size, e.size);
                    if (i_conceal_run != e.run) report("run", i_conceal_run, e.run);
                    if (i_last_of_run != e.last) report("last", i_last_of_run, e.last);
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ajrb_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        req_type;
    logic [SEQ_W-1:0]  req_seq;
    logic [HDL_W-1:0]  req_handle;
    logic [SIZE_W-1:0] req_size;
    logic              cfg_we;
    logic [PF_W-1:0]   cfg_data;
    logic              res_valid;
    logic              res_ready;
    logic [1:0]        res_kind;
    logic [SEQ_W-1:0]  res_seq;
    logic [HDL_W-1:0]  res_handle;
    logic [SIZE_W-1:0] res_size;
    logic [RUN_W-1:0]  res_run;
    logic              res_last;
    int                errors;
    int                pending;
    logic              hold_off;
    int                stall_mode;
    logic [SEQ_W-1:0]  stream_base;

    audio_jitter_reorder_buffer i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_req_type(req_type), .i_seq_number(req_seq),
        .i_payload_handle(req_handle), .i_payload_size(req_size),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_result_kind(res_kind), .o_out_seq(res_seq), .o_out_handle(res_handle),
        .o_out_size(res_size), .o_conceal_run(res_run), .o_last_of_run(res_last)
    );

    ajrb_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .i_ready_in(req_ready),
        .i_req_type(req_type), .i_seq_number(req_seq),
        .i_payload_handle(req_handle), .i_payload_size(req_size),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_out_valid(res_valid), .i_out_ready(res_ready),
        .i_result_kind(res_kind), .i_out_seq(res_seq), .i_out_handle(res_handle),
        .i_out_size(res_size), .i_conceal_run(res_run), .i_last_of_run(res_last),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Receiver stalls follow a mode changed by the stimulus; a long hold-off overrides all.
    always @(negedge clk) begin
        if (hold_off) res_ready <= 1'b0;
        else case (stall_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 3) != 0);
            default: res_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // Offers one request and holds it until accepted; gaps are made by the caller.
    task automatic send(t_req_kind k, logic [SEQ_W-1:0] s, logic [HDL_W-1:0] h,
                        logic [SIZE_W-1:0] z);
        req_valid <= 1'b1;
        req_type <= k; req_seq <= s; req_handle <= h; req_size <= z;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause(int n);
        req_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_and_config(logic [PF_W-1:0] value);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we <= 1'b1; cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_audio();
        logic [SEQ_W-1:0] s;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) s = stream_base + SEQ_W'($urandom_range(0, 12));
        else if (pick < 90) s = stream_base - SEQ_W'($urandom_range(1, 20));
        else s = SEQ_W'($urandom);
        send(REQ_AUDIO, s, HDL_W'($urandom), SIZE_W'($urandom));
        if ($urandom_range(0, 2) == 0)
            stream_base = stream_base + SEQ_W'($urandom_range(1, 4));
    endtask

    initial begin
        int burst;
        rst_n = 1'b0;
        req_valid = 1'b0; req_type = REQ_AUDIO; req_seq = '0;
        req_handle = '0; req_size = '0;
        cfg_we = 1'b0; cfg_data = '0;
        res_ready = 1'b0; hold_off = 1'b0; stall_mode = 0;
        stream_base = 16'd100;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: in-order start, a gap, late and duplicate units, haptics, restart.
        send(REQ_AUDIO, 16'd10, 16'hFFFF, 8'hFF);
        send(REQ_AUDIO, 16'd12, 16'h0000, 8'h00);
        send(REQ_AUDIO, 16'd11, 16'h5555, 8'hAA);
        send(REQ_AUDIO, 16'd11, 16'hAAAA, 8'h55);
        send(REQ_AUDIO, 16'd5, 16'h1234, 8'h12);
        send(REQ_AUDIO, 16'd16, 16'h2222, 8'h22);
        send(REQ_AUDIO, 16'd17, 16'h3333, 8'h33);
        send(REQ_AUDIO, 16'd18, 16'h4444, 8'h44);
        send(REQ_HAPTIC, 16'd40, 16'h7777, 8'h77);
        send(REQ_HAPTIC, 16'd3, 16'h8888, 8'h88);
        send(REQ_HAPTIC, 16'hFFFF, 16'hFFFF, 8'hFF);
        send(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        send(REQ_RESTART, 16'h0000, 16'h0000, 8'h00);
        send(REQ_AUDIO, 16'hFFFF, 16'h0001, 8'h01);
        send(REQ_AUDIO, 16'h7FFF, 16'h0002, 8'h02);
        send(REQ_RESTART, 16'h0000, 16'h0000, 8'h00);

        // Prefill above the slot count: fill up, then evict the newest or drop the incoming.
        drain_and_config(4'd15);
        for (int i = 0; i < 8; i++)
            send(REQ_AUDIO, SEQ_W'(200 + 2 * i), HDL_W'(i), SIZE_W'(i));
        send(REQ_AUDIO, 16'd201, 16'hBEEF, 8'h01);
        send(REQ_AUDIO, 16'd300, 16'hCAFE, 8'h02);
        send(REQ_RESTART, 16'h0000, 16'h0000, 8'h00);
        drain_and_config(4'd0);
        send(REQ_AUDIO, 16'd50, 16'h0050, 8'h05);
        send(REQ_AUDIO, 16'd53, 16'h0053, 8'h06);

        // Random phases across prefill settings and receiver behaviors.
        for (int phase = 0; phase < 6; phase++) begin
            drain_and_config(phase == 0 ? 4'd1 : phase == 1 ? 4'd8 :
                             phase == 5 ? 4'd15 : 4'($urandom_range(0, 8)));
            stall_mode = phase % 3;
            for (int n = 0; n < 67; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 67; b++, n++) begin
                    case ($urandom_range(0, 29))
                        0: send(REQ_RESTART, SEQ_W'($urandom), HDL_W'($urandom),
                                SIZE_W'($urandom));
                        1: send(REQ_UNUSED, SEQ_W'($urandom), HDL_W'($urandom),
                                SIZE_W'($urandom));
                        2, 3: send(REQ_HAPTIC, $urandom_range(0, 1) ?
                                   stream_base + SEQ_W'($urandom_range(0, 8)) :
                                   SEQ_W'($urandom),
                                   HDL_W'($urandom), SIZE_W'($urandom));
                        default: random_audio();
                    endcase
                end
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 30));
            end
        end

        // Long receiver hold-off while the sender keeps offering.
        drain_and_config(4'd2);
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 40; n++) random_audio();
        join

        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
